@@ rtl/dofr_pkg.sv @@
// shared types, register map constants and status helpers for the dac output fifo unit
// no dependencies
package dofr_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TRIG  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef logic [4:0]  ptr_t;
  typedef logic [5:0]  fill_t;
  typedef logic [13:0] sample_t;

  // register byte offsets
  localparam logic [5:0] ADDR_VERID = 6'h00;
  localparam logic [5:0] ADDR_PARAM = 6'h04;
  localparam logic [5:0] ADDR_DATA  = 6'h08;
  localparam logic [5:0] ADDR_GCR   = 6'h0C;
  localparam logic [5:0] ADDR_FCR   = 6'h10;
  localparam logic [5:0] ADDR_FPR   = 6'h14;
  localparam logic [5:0] ADDR_FSR   = 6'h18;
  localparam logic [5:0] ADDR_IER   = 6'h1C;
  localparam logic [5:0] ADDR_DER   = 6'h20;
  localparam logic [5:0] ADDR_RCR   = 6'h24;
  localparam logic [5:0] ADDR_TCR   = 6'h28;

  // register word indexes
  localparam logic [3:0] W_GCR = 4'd3;
  localparam logic [3:0] W_FCR = 4'd4;
  localparam logic [3:0] W_FSR = 4'd6;
  localparam logic [3:0] W_IER = 4'd7;
  localparam logic [3:0] W_DER = 4'd8;
  localparam logic [3:0] W_RCR = 4'd9;

  localparam logic [31:0] VERID_VALUE = 32'h0100_0000;
  localparam logic [31:0] PARAM_HP    = 32'd4;
  localparam logic [31:0] PARAM_STD   = 32'd3;

  localparam int GCR_EN_BIT   = 0;
  localparam int GCR_FIFO_BIT = 3;
  localparam int GCR_TSEL_BIT = 5;
  localparam int RCR_SRST_BIT = 0;
  localparam int RCR_FRST_BIT = 1;
  localparam int TCR_SWT_BIT  = 0;

  localparam logic [31:0] FS_FULL    = 32'h0000_0001;
  localparam logic [31:0] FS_EMPTY   = 32'h0000_0002;
  localparam logic [31:0] FS_WM      = 32'h0000_0004;
  localparam logic [31:0] FS_OF      = 32'h0000_0040;
  localparam logic [31:0] FS_UF      = 32'h0000_0080;
  localparam logic [31:0] FS_LATCHED = 32'h0000_01C8;

  localparam fill_t DEPTH_HP  = 6'd32;
  localparam fill_t DEPTH_STD = 6'd16;

  // config port register index
  localparam logic CFG_HP = 1'b0;

  typedef struct packed {
    logic    en;
    ptr_t    ptr;
    sample_t data;
  } ring_wr_t;

  typedef struct packed {
    logic        en;
    logic [31:0] data;
  } mem_wr_t;

  function automatic fill_t ring_depth(input logic hp);
    return hp ? DEPTH_HP : DEPTH_STD;
  endfunction

  function automatic ptr_t ptr_inc(input ptr_t ptr, input logic hp);
    logic [3:0] low;
    low = ptr[3:0] + 4'd1;
    return hp ? ptr_t'(ptr + 5'd1) : {1'b0, low};
  endfunction

  // full, empty and watermark derived from the fill count, plus latched flags
  function automatic logic [31:0] status_word(input logic [31:0] fsr,
                                              input logic [31:0] fcr,
                                              input fill_t fill,
                                              input logic hp);
    logic [31:0] s;
    logic [4:0]  wml;
    s   = fsr & FS_LATCHED;
    wml = hp ? fcr[4:0] : {1'b0, fcr[3:0]};
    if (fill == 6'd0) s = s | FS_EMPTY;
    if (fill >= ring_depth(hp)) s = s | FS_FULL;
    if (fill <= {1'b0, wml}) s = s | FS_WM;
    return s;
  endfunction

  // byte lane mask for a sub-word write
  function automatic logic [31:0] merge_mask(input logic [2:0] size, input logic [1:0] off);
    logic [31:0] m;
    case (size)
      3'd0: m = 32'h0000_0000;
      3'd1: m = 32'h0000_00FF;
      3'd2: m = 32'h0000_FFFF;
      3'd3: m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    if (size < 3'd4) m = m << {off, 3'b000};
    return m;
  endfunction

endpackage

@@ rtl/dofr_ring.sv @@
// sample ring memory with a registered prefetch of the read pointer entry
// depends on dofr_pkg
module dofr_ring #(
  parameter int RING_MAX = 32
) (
  input  logic              clk_i,
  input  dofr_pkg::ring_wr_t wr_i,
  input  dofr_pkg::ptr_t    rd_ptr_i,
  output dofr_pkg::sample_t rd_data_o
);

  localparam int RW = $clog2(RING_MAX);

  dofr_pkg::sample_t ring_mem [RING_MAX];
  dofr_pkg::sample_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ring_mem[RW'(wr_i.ptr)] <= wr_i.data;
    end
    // forward a write landing on the entry being prefetched
    if (wr_i.en && (wr_i.ptr == rd_ptr_i)) begin
      rd_data_q <= wr_i.data;
    end else begin
      rd_data_q <= ring_mem[RW'(rd_ptr_i)];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/dofr_regmem.sv @@
// register word memory with read forwarding and a clearing sweep after reset and on clear_i
// depends on dofr_pkg
module dofr_regmem #(
  parameter int REG_WORDS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(REG_WORDS)-1:0] rd_addr_i,
  input  dofr_pkg::mem_wr_t            wr_i,
  input  logic [$clog2(REG_WORDS)-1:0] wr_addr_i,
  output logic [31:0]                  rd_data_o,
  output logic                         busy_o
);

  localparam int AW = $clog2(REG_WORDS);

  logic [31:0]   reg_mem [REG_WORDS];
  logic [31:0]   rd_data_q;
  logic          busy_q, busy_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  always_comb begin
    we = busy_q | wr_i.en;
    wa = busy_q ? sweep_q : wr_addr_i;
    wd = busy_q ? 32'h0 : wr_i.data;
  end

  always_comb begin
    busy_d  = busy_q;
    sweep_d = sweep_q;
    if (clear_i) begin
      busy_d  = 1'b1;
      sweep_d = '0;
    end else if (busy_q) begin
      sweep_d = sweep_q + AW'(1);
      if (sweep_q == AW'(REG_WORDS - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      sweep_q <= '0;
    end else begin
      busy_q  <= busy_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      reg_mem[wa] <= wd;
    end
    if (rd_en_i) begin
      if (we && (wa == rd_addr_i)) begin
        rd_data_q <= wd;
      end else begin
        rd_data_q <= reg_mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

@@ rtl/dac_output_fifo_registers_unit.sv @@
// top level of the dac output fifo register unit: decode, fifo control, status
// depends on dofr_pkg, dofr_ring and dofr_regmem
//
// usage
//   each item on the input channel is a bus read, a bus write or a hardware
//   trigger edge; every item gives exactly one result item carrying the read
//   data, the held converter sample and the interrupt and dma request levels
//   the apb port sets high performance mode (14 bit samples, 32 deep ring);
//   the user must write it only while no items are in flight; not enforced
// timing
//   one item per cycle sustained while out_ready_i is high and no sweep runs;
//   an accepted item is executed in the execute stage and its result is
//   registered in the output register, from which it is offered
//   the execute stage reads the register word memory and the sample ring
//   prefetch register, both registered reads, and writes them back in the
//   same cycle; a read that meets a write to the same word is forwarded
// reset
//   after reset and after a soft reset the register word memory is swept to
//   zero, one word a cycle, with in_ready_o low; apb writes are still taken;
//   ring contents are kept, pointers and counts clear
// stalls
//   with out_ready_i low one result waits in the output register and one more
//   item may sit in the execute stage; then in_ready_o drops
module dac_output_fifo_registers_unit #(
  parameter int REG_WORDS = 16,
  parameter int RING_MAX  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  address_i,
  input  logic [31:0] write_data_i,
  input  logic [2:0]  access_size_i,
  input  logic        trigger_level_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [13:0] analog_output_o,
  output logic        interrupt_o,
  output logic        dma_request_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(REG_WORDS);

  // configuration register
  logic hp_q;

  // execute stage
  logic        s1_valid_q;
  logic [1:0]  s1_op_q;
  logic [5:0]  s1_addr_q;
  logic [31:0] s1_data_q;
  logic [2:0]  s1_size_q;
  logic        s1_lvl_q;
  logic        s1_srst_q;
  logic        s1_fire;
  logic        in_accept;

  // hot registers kept in flops
  logic [31:0] gcr_q, gcr_d;
  logic [31:0] fcr_q, fcr_d;
  logic [31:0] fsr_q, fsr_d;
  logic [31:0] ier_q, ier_d;
  logic [31:0] der_q, der_d;

  // fifo state
  dofr_pkg::ptr_t    wptr_q, wptr_d;
  dofr_pkg::ptr_t    rptr_q, rptr_d, rptr_nxt;
  dofr_pkg::fill_t   fill_q, fill_d;
  dofr_pkg::sample_t held_q, held_d;

  // output register
  logic        out_valid_q;
  logic [31:0] out_rdata_q;
  logic [13:0] out_analog_q;
  logic        out_irq_q;
  logic        out_dma_q;

  // memories
  dofr_pkg::ring_wr_t ring_wr;
  dofr_pkg::sample_t  ring_rd;
  dofr_pkg::mem_wr_t  mem_wr;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_rd;
  logic               mem_busy;

  // execute stage decode
  logic [3:0]        s1_word;
  logic              in_range;
  logic [31:0]       word_cur;
  logic [31:0]       merge_m;
  logic [31:0]       merge_d;
  logic [31:0]       merged;
  logic [31:0]       rdata;
  logic [31:0]       fs_new;
  logic              irq;
  logic              dma;
  logic              push_req;
  logic              pop_req;
  logic              fclr;
  logic              srst;
  dofr_pkg::sample_t sample;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == dofr_pkg::CFG_HP)) begin
      hp_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == dofr_pkg::CFG_HP) ? {31'h0, hp_q} : 32'h0;
  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  // a soft reset in execute holds off new items until the sweep has begun
  assign in_ready_o = !mem_busy && !(s1_valid_q && s1_srst_q) && (!s1_valid_q || s1_fire);
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q   <= operation_i;
      s1_addr_q <= address_i;
      s1_data_q <= write_data_i;
      s1_size_q <= access_size_i;
      s1_lvl_q  <= trigger_level_i;
      s1_srst_q <= (operation_i == dofr_pkg::OP_WRITE) && (address_i == dofr_pkg::ADDR_RCR)
                   && write_data_i[dofr_pkg::RCR_SRST_BIT];
    end
  end

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  dofr_regmem #(
    .REG_WORDS(REG_WORDS)
  ) u_regmem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (s1_fire && srst),
    .rd_en_i  (in_accept),
    .rd_addr_i(AW'(address_i[5:2])),
    .wr_i     (mem_wr),
    .wr_addr_i(mem_waddr),
    .rd_data_o(mem_rd),
    .busy_o   (mem_busy)
  );

  // the ring prefetches the entry at the next read pointer every cycle
  assign rptr_nxt = s1_fire ? rptr_d : rptr_q;

  dofr_ring #(
    .RING_MAX(RING_MAX)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_i     (ring_wr),
    .rd_ptr_i (rptr_nxt),
    .rd_data_o(ring_rd)
  );

  // ---------------------------------------------------------------------------
  // execute: decode, read-modify-write, fifo push and pop
  // ---------------------------------------------------------------------------
  assign s1_word  = s1_addr_q[5:2];
  assign in_range = (32'(s1_word) < 32'(REG_WORDS));
  assign merge_m  = dofr_pkg::merge_mask(s1_size_q, s1_addr_q[1:0]);
  assign merge_d  = s1_data_q << {s1_addr_q[1:0], 3'b000};
  assign merged   = (word_cur & ~merge_m) | (merge_d & merge_m);
  assign sample   = hp_q ? s1_data_q[13:0] : {2'b00, s1_data_q[11:0]};

  always_comb begin
    case (s1_word)
      dofr_pkg::W_GCR: word_cur = gcr_q;
      dofr_pkg::W_FCR: word_cur = fcr_q;
      dofr_pkg::W_FSR: word_cur = fsr_q;
      dofr_pkg::W_IER: word_cur = ier_q;
      dofr_pkg::W_DER: word_cur = der_q;
      default:         word_cur = in_range ? mem_rd : 32'h0;
    endcase
  end

  always_comb begin
    gcr_d     = gcr_q;
    fcr_d     = fcr_q;
    fsr_d     = fsr_q;
    ier_d     = ier_q;
    der_d     = der_q;
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    fill_d    = fill_q;
    held_d    = held_q;
    rdata     = 32'h0;
    mem_wr    = '0;
    mem_waddr = AW'(s1_word);
    ring_wr   = '0;
    push_req  = 1'b0;
    pop_req   = 1'b0;
    fclr      = 1'b0;
    srst      = 1'b0;

    case (s1_op_q)
      dofr_pkg::OP_READ: begin
        case (s1_addr_q)
          dofr_pkg::ADDR_VERID: rdata = dofr_pkg::VERID_VALUE;
          dofr_pkg::ADDR_PARAM: rdata = hp_q ? dofr_pkg::PARAM_HP : dofr_pkg::PARAM_STD;
          dofr_pkg::ADDR_DATA:  rdata = 32'h0;
          dofr_pkg::ADDR_TCR:   rdata = 32'h0;
          dofr_pkg::ADDR_FPR:   rdata = {11'h0, wptr_q, 11'h0, rptr_q};
          dofr_pkg::ADDR_FSR:   rdata = dofr_pkg::status_word(fsr_q, fcr_q, fill_q, hp_q);
          default:              rdata = word_cur;
        endcase
      end
      dofr_pkg::OP_WRITE: begin
        case (s1_addr_q)
          dofr_pkg::ADDR_VERID: ;
          dofr_pkg::ADDR_PARAM: ;
          dofr_pkg::ADDR_FPR:   ;
          dofr_pkg::ADDR_DATA:  push_req = 1'b1;
          dofr_pkg::ADDR_TCR:   pop_req = s1_data_q[dofr_pkg::TCR_SWT_BIT];
          dofr_pkg::ADDR_FSR:   fsr_d = fsr_q & ~(s1_data_q & dofr_pkg::FS_LATCHED);
          dofr_pkg::ADDR_GCR:   gcr_d = s1_data_q;
          dofr_pkg::ADDR_FCR:   fcr_d = s1_data_q;
          dofr_pkg::ADDR_IER:   ier_d = s1_data_q;
          dofr_pkg::ADDR_DER:   der_d = s1_data_q;
          dofr_pkg::ADDR_RCR: begin
            if (s1_data_q[dofr_pkg::RCR_SRST_BIT]) begin
              srst = 1'b1;
            end else begin
              fclr = s1_data_q[dofr_pkg::RCR_FRST_BIT];
              // an aligned control word write stores zero, so it reads back as zero
              mem_wr.en   = 1'b1;
              mem_wr.data = 32'h0;
              mem_waddr   = AW'(dofr_pkg::W_RCR);
            end
          end
          default: begin
            if (in_range) begin
              case (s1_word)
                dofr_pkg::W_GCR: gcr_d = merged;
                dofr_pkg::W_FCR: fcr_d = merged;
                dofr_pkg::W_FSR: fsr_d = merged;
                dofr_pkg::W_IER: ier_d = merged;
                dofr_pkg::W_DER: der_d = merged;
                default: begin
                  mem_wr.en   = 1'b1;
                  mem_wr.data = merged;
                end
              endcase
            end
          end
        endcase
      end
      dofr_pkg::OP_TRIG: begin
        pop_req = s1_lvl_q && !gcr_q[dofr_pkg::GCR_TSEL_BIT];
      end
      default: ;
    endcase

    // push: direct drive when the fifo is off, else queue or flag overflow
    if (push_req) begin
      if (!gcr_q[dofr_pkg::GCR_FIFO_BIT]) begin
        held_d = sample;
      end else if (fill_q >= dofr_pkg::ring_depth(hp_q)) begin
        fsr_d = fsr_d | dofr_pkg::FS_OF;
      end else begin
        ring_wr.en   = 1'b1;
        ring_wr.ptr  = wptr_q;
        ring_wr.data = sample;
        wptr_d       = dofr_pkg::ptr_inc(wptr_q, hp_q);
        fill_d       = fill_q + 6'd1;
      end
    end

    // pop: needs both enable and fifo mode
    if (pop_req && gcr_q[dofr_pkg::GCR_EN_BIT] && gcr_q[dofr_pkg::GCR_FIFO_BIT]) begin
      if (fill_q == 6'd0) begin
        fsr_d = fsr_d | dofr_pkg::FS_UF;
      end else begin
        held_d = ring_rd;
        rptr_d = dofr_pkg::ptr_inc(rptr_q, hp_q);
        fill_d = fill_q - 6'd1;
      end
    end

    if (fclr) begin
      wptr_d = '0;
      rptr_d = '0;
      fill_d = '0;
      fsr_d  = fsr_q & ~dofr_pkg::FS_LATCHED;
    end

    if (srst) begin
      gcr_d  = 32'h0;
      fcr_d  = 32'h0;
      fsr_d  = 32'h0;
      ier_d  = 32'h0;
      der_d  = 32'h0;
      wptr_d = '0;
      rptr_d = '0;
      fill_d = '0;
      held_d = '0;
    end

    mem_wr.en  = mem_wr.en && s1_fire;
    ring_wr.en = ring_wr.en && s1_fire;
  end

  // levels after the item has taken effect
  always_comb begin
    fs_new = dofr_pkg::status_word(fsr_d, fcr_d, fill_d, hp_q);
    irq    = |(fs_new & ier_d);
    dma    = (fs_new[2] & der_d[2]) | (fs_new[1] & der_d[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcr_q  <= 32'h0;
      fcr_q  <= 32'h0;
      fsr_q  <= 32'h0;
      ier_q  <= 32'h0;
      der_q  <= 32'h0;
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
      held_q <= '0;
    end else if (s1_fire) begin
      gcr_q  <= gcr_d;
      fcr_q  <= fcr_d;
      fsr_q  <= fsr_d;
      ier_q  <= ier_d;
      der_q  <= der_d;
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
      held_q <= held_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_rdata_q  <= rdata;
      out_analog_q <= held_d;
      out_irq_q    <= irq;
      out_dma_q    <= dma;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_rdata_q;
  assign analog_output_o = out_analog_q;
  assign interrupt_o     = out_irq_q;
  assign dma_request_o   = out_dma_q;

endmodule

@@ rtl/dofr_checker.sv @@
// port level checks on item flow for the dac output fifo unit, bound to the top level
// depends on dac_output_fifo_registers_unit
module dofr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_data_o,
  input logic [13:0] analog_output_o
);

  logic [1:0] cnt_q;
  logic       acc;
  logic       del;

  assign acc = in_valid_i && in_ready_o;
  assign del = out_valid_o && out_ready_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(acc) - 2'(del);
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(analog_output_o))
    else $error("result changed while stalled");

  a_inflight_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("more than two items in flight");

  a_no_invent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !out_valid_o)
    else $error("result without an item");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    del && cnt_q == 2'd1 && !acc |=> !out_valid_o)
    else $error("result repeated after drain");

  a_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !out_ready_i |-> !in_ready_o)
    else $error("item taken with both stages full");

endmodule

bind dac_output_fifo_registers_unit dofr_checker u_dofr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .read_data_o    (read_data_o),
  .analog_output_o(analog_output_o)
);
